// File: rtl/swr_pkg.sv
// Shared types and constants of the sliding-window reorder receiver.
`default_nettype none
package swr_pkg;

    localparam int WINDOW_DEPTH = 32;
    localparam int REF_W        = 16;
    localparam int SEQ_W        = 32;
    localparam int WIN_W        = 6;
    localparam int SLOT_IDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] KIND_DELIVER = 2'd0;
    localparam logic [1:0] KIND_ACK     = 2'd1;
    localparam logic [1:0] KIND_FIN     = 2'd2;

    typedef struct packed {
        logic [SEQ_W-1:0] seq_num;
        logic             fin_flag;
        logic [REF_W-1:0] payload_ref;
    } q_item_t;

    typedef struct packed {
        logic [WIN_W-1:0] window_size;
        logic             ack_load;
        logic [SEQ_W-1:0] ack_init;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [REF_W-1:0] out_ref;
        logic [SEQ_W-1:0] ack_value;
        logic [WIN_W-1:0] free_slots;
        logic             last;
    } out_item_t;

endpackage
`default_nettype wire

// File: rtl/sliding_window_reorder_receiver.sv
// Results: a delivery or FIN result is registered in the classify state, the ack of a stored item
// in the pick state after a match state; the closing ack of a delivery follows a match and a pick.
// The engine works one item at a time: idle, classify, then match and pick for a delivered or stored
// item, plus a match and a pick per buffered item drained; ignored and FIN items end after classify.
// Reset (aresetn low, synchronous): window_size = 32, ack number = 0, store empty, session open.
// The store needs no clearing pass; its valid bits clear at once.
`default_nettype none
module sliding_window_reorder_receiver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Packet header items.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // seq_num[31:0], payload_ref[47:32]
    input  wire logic [1:0]  s_tuser,   // sum_ok[0], fin_flag[1]
    // Result items.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // out_ref[15:0], ack_value[47:16], free_slots[53:48], 0
    output logic [1:0]       m_tuser,   // kind[1:0]
    output logic             m_tlast,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import swr_pkg::*;

    localparam logic REG_WINDOW_SIZE = 1'b0;
    localparam logic REG_START_ACK   = 1'b1;

    logic [WIN_W-1:0] window_size_reg;
    logic [SEQ_W-1:0] start_ack_reg;
    logic             cfg_write;
    cfg_t             cfg;

    logic             push_valid;
    logic             push_ready;
    q_item_t          push_item;
    logic             pop_valid;
    logic             pop_ready;
    q_item_t          pop_item;
    out_item_t        out_item;

    // Registers sit at byte addresses 0 and 4; address bit 2 picks one.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_START_ACK) ? start_ack_reg
                                                   : {{(32 - WIN_W){1'b0}}, window_size_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= WIN_W'(32);
            start_ack_reg   <= '0;
        end else if (cfg_write) begin
            if (paddr[2] == REG_WINDOW_SIZE) begin
                window_size_reg <= pwdata[WIN_W-1:0];
            end else begin
                start_ack_reg <= pwdata;
            end
        end
    end

    // Writing start_ack also reloads the acknowledged number in the engine.
    assign cfg.window_size = window_size_reg;
    assign cfg.ack_load    = cfg_write && (paddr[2] == REG_START_ACK);
    assign cfg.ack_init    = pwdata;

    // Front: input register that discards items with a failed checksum.
    swr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Queue: lets the front keep taking items while the engine drains the store.
    swr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Back: classifies against the window, stores, drains and emits results through its own
    // output register, so a stalled consumer holds the engine and, once the queue fills, the input.
    swr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_item    (out_item)
    );

    assign m_tdata = {2'b00, out_item.free_slots, out_item.ack_value, out_item.out_ref};
    assign m_tuser = out_item.kind;
    assign m_tlast = out_item.last;

endmodule
`default_nettype wire

// File: rtl/swr_front.sv
// Input stage: takes packet headers, drops failed checksums, hands the rest to the queue.
`default_nettype none
module swr_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [47:0]     s_tdata,   // seq_num[31:0], payload_ref[47:32]
    input  wire logic [1:0]      s_tuser,   // sum_ok[0], fin_flag[1]
    output logic                 push_valid,
    input  wire logic            push_ready,
    output swr_pkg::q_item_t     push_item
);
    import swr_pkg::*;

    logic    hold_valid_reg;
    q_item_t hold_item_reg;

    // The holding register frees up whenever its item moves on to the queue.
    assign s_tready   = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_item  = hold_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (s_tready) begin
            hold_valid_reg <= s_tvalid && s_tuser[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            hold_item_reg.seq_num     <= s_tdata[SEQ_W-1:0];
            hold_item_reg.payload_ref <= s_tdata[SEQ_W +: REF_W];
            hold_item_reg.fin_flag    <= s_tuser[1];
        end
    end

endmodule
`default_nettype wire

// File: rtl/swr_queue.sv
// Short FIFO that decouples the input stage from the window engine.
`default_nettype none
module swr_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire swr_pkg::q_item_t push_item,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output swr_pkg::q_item_t     pop_item
);
    import swr_pkg::*;

    q_item_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        ptr_inc = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// File: rtl/swr_back.sv
// Window engine: reorder store, ack tracking, drain sequencer and result register.
`default_nettype none
module swr_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire swr_pkg::cfg_t    cfg,
    input  wire logic             pop_valid,
    output logic                  pop_ready,
    input  wire swr_pkg::q_item_t pop_item,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output swr_pkg::out_item_t    m_item
);
    import swr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_CLASSIFY = 4'b0010,
        ST_MATCH    = 4'b0100,
        ST_PICK     = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    q_item_t                 cur_reg;
    logic [SEQ_W-1:0]        acked_reg, acked_next;
    logic [WIN_W-1:0]        held_reg, held_next;
    logic                    session_done_reg, session_done_next;
    logic [SEQ_W-1:0]        key_reg, key_next;
    logic                    drain_reg, drain_next;
    logic [WINDOW_DEPTH-1:0] slot_valid_reg;
    logic [SEQ_W-1:0]        slot_seq_reg [WINDOW_DEPTH];
    logic [REF_W-1:0]        slot_ref_reg [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] match_reg;
    logic                    m_valid_reg;
    out_item_t               m_item_reg;

    logic [WIN_W-1:0]        eff;
    logic [SEQ_W-1:0]        seq_delta;
    logic                    in_order;
    logic                    in_window;
    logic                    match_any;
    logic [SLOT_IDX_W-1:0]   match_idx;
    logic [SLOT_IDX_W-1:0]   free_idx;
    logic                    out_free;
    logic                    emit;
    out_item_t               emit_item;
    logic                    wr_en;
    logic                    clr_en;

    function automatic logic [WIN_W-1:0] free_of(input logic [WIN_W-1:0] w,
                                                 input logic [WIN_W-1:0] h);
        free_of = (w > h) ? w - h : '0;
    endfunction

    function automatic logic [SLOT_IDX_W-1:0] first_set(input logic [WINDOW_DEPTH-1:0] v);
        logic [SLOT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = WINDOW_DEPTH - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = SLOT_IDX_W'(i);
            end
        end
        first_set = idx;
    endfunction

    assign eff       = (cfg.window_size < WIN_W'(WINDOW_DEPTH)) ? cfg.window_size
                                                                : WIN_W'(WINDOW_DEPTH);
    assign seq_delta = cur_reg.seq_num - acked_reg;
    assign in_order  = (seq_delta == SEQ_W'(1));
    assign in_window = (seq_delta >= SEQ_W'(2)) && (seq_delta <= SEQ_W'(eff)) &&
                       (held_reg < eff);
    assign match_any = |match_reg;
    assign match_idx = first_set(match_reg);
    assign free_idx  = first_set(~slot_valid_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign pop_ready = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    always_comb begin
        state_next        = state_reg;
        acked_next        = acked_reg;
        held_next         = held_reg;
        session_done_next = session_done_reg;
        key_next          = key_reg;
        drain_next        = drain_reg;
        emit              = 1'b0;
        emit_item         = '0;
        wr_en             = 1'b0;
        clr_en            = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                if (session_done_reg) begin
                    state_next = ST_IDLE;
                end else if (cur_reg.fin_flag) begin
                    if (out_free) begin
                        emit                 = 1'b1;
                        emit_item.kind       = KIND_FIN;
                        emit_item.ack_value  = cur_reg.seq_num;
                        emit_item.free_slots = free_of(eff, held_reg);
                        emit_item.last       = 1'b1;
                        session_done_next    = 1'b1;
                        state_next           = ST_IDLE;
                    end
                end else if (in_order) begin
                    if (out_free) begin
                        emit                 = 1'b1;
                        emit_item.kind       = KIND_DELIVER;
                        emit_item.out_ref    = cur_reg.payload_ref;
                        emit_item.ack_value  = cur_reg.seq_num;
                        emit_item.free_slots = free_of(eff, held_reg);
                        acked_next           = cur_reg.seq_num;
                        key_next             = cur_reg.seq_num + 1'b1;
                        drain_next           = 1'b1;
                        state_next           = ST_MATCH;
                    end
                end else if (in_window) begin
                    key_next   = cur_reg.seq_num;
                    drain_next = 1'b0;
                    state_next = ST_MATCH;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MATCH: begin
                state_next = ST_PICK;
            end
            ST_PICK: begin
                if (drain_reg) begin
                    if (match_any) begin
                        if (out_free) begin
                            emit                 = 1'b1;
                            clr_en               = 1'b1;
                            held_next            = (held_reg != '0) ? held_reg - 1'b1 : '0;
                            emit_item.kind       = KIND_DELIVER;
                            emit_item.out_ref    = slot_ref_reg[match_idx];
                            emit_item.ack_value  = key_reg;
                            emit_item.free_slots = free_of(eff, held_next);
                            acked_next           = key_reg;
                            key_next             = key_reg + 1'b1;
                            state_next           = ST_MATCH;
                        end
                    end else if (out_free) begin
                        emit                 = 1'b1;
                        emit_item.kind       = KIND_ACK;
                        emit_item.ack_value  = acked_reg;
                        emit_item.free_slots = free_of(eff, held_reg);
                        emit_item.last       = 1'b1;
                        state_next           = ST_IDLE;
                    end
                end else if (match_any) begin
                    // Already stored: dropped silently.
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    wr_en                = 1'b1;
                    held_next            = held_reg + 1'b1;
                    emit                 = 1'b1;
                    emit_item.kind       = KIND_ACK;
                    emit_item.ack_value  = acked_reg;
                    emit_item.free_slots = free_of(eff, held_next);
                    emit_item.last       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            acked_reg        <= '0;
            held_reg         <= '0;
            session_done_reg <= 1'b0;
            drain_reg        <= 1'b0;
            slot_valid_reg   <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            held_reg         <= held_next;
            session_done_reg <= session_done_next;
            drain_reg        <= drain_next;
            if (cfg.ack_load) begin
                acked_reg <= cfg.ack_init;
            end else begin
                acked_reg <= acked_next;
            end
            if (wr_en) begin
                slot_valid_reg[free_idx] <= 1'b1;
            end
            if (clr_en) begin
                slot_valid_reg[match_idx] <= 1'b0;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_valid && pop_ready) begin
            cur_reg <= pop_item;
        end
        key_reg <= key_next;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            match_reg[i] <= slot_valid_reg[i] && (slot_seq_reg[i] == key_reg);
        end
        if (wr_en) begin
            slot_seq_reg[free_idx] <= cur_reg.seq_num;
            slot_ref_reg[free_idx] <= cur_reg.payload_ref;
        end
        if (emit) begin
            m_item_reg <= emit_item;
        end
    end

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench of the sliding-window reorder receiver: stream stimulus, predictor, checker.
module testbench;
    import swr_pkg::*;

    // Register map of the configuration port.
    localparam logic [2:0] ADDR_WINDOW    = 3'd0;
    localparam logic [2:0] ADDR_START_ACK = 3'd4;

    // Quiet cycles after the last expected result, well beyond the block's latency.
    localparam int SETTLE_CYCLES     = 40;
    localparam int LONG_STALL_CYCLES = 300;

    typedef struct {
        logic [SEQ_W-1:0] seq_num;
        logic             sum_ok;
        logic             fin_flag;
        logic [REF_W-1:0] payload_ref;
    } header_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [47:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [55:0] m_tdata;
    wire  [1:0]  m_tuser;
    wire         m_tlast;
    wire  [31:0] prdata;
    wire         pready;

    sliding_window_reorder_receiver u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    // Predicted receiver state, updated at every accepted item and register write.
    logic [WIN_W-1:0] pred_window = 6'd32;
    logic [SEQ_W-1:0] pred_acked  = '0;
    bit               pred_slot_valid [WINDOW_DEPTH];
    logic [SEQ_W-1:0] pred_slot_seq   [WINDOW_DEPTH];
    logic [REF_W-1:0] pred_slot_ref   [WINDOW_DEPTH];
    int               pred_held   = 0;
    bit               pred_done   = 1'b0;

    header_t   pending_headers[$];
    out_item_t expected_results[$];
    out_item_t want;
    header_t   next_hdr;

    int pushed_count    = 0;
    int accepted_items  = 0;
    int mismatch_count  = 0;
    int send_gap        = 0;
    int ready_gap       = 0;
    int stall_left      = 0;
    bit stall_done      = 1'b0;
    bit in_taken        = 1'b0;
    bit quiet           = 1'b0;

    function automatic int window_limit();
        return (pred_window < WINDOW_DEPTH) ? int'(pred_window) : WINDOW_DEPTH;
    endfunction

    function automatic void push_result(logic [1:0] kind, logic [REF_W-1:0] handle,
                                        logic [SEQ_W-1:0] ackv, logic last_flag);
        out_item_t r;
        int        w;
        w            = window_limit();
        r.kind       = kind;
        r.out_ref    = handle;
        r.ack_value  = ackv;
        r.free_slots = (w > pred_held) ? WIN_W'(w - pred_held) : '0;
        r.last       = last_flag;
        expected_results.insert(expected_results.size(), r);
    endfunction

    // Works out the results that one accepted packet header causes.
    function automatic void predict_results(logic [SEQ_W-1:0] seq, logic ok, logic fin,
                                            logic [REF_W-1:0] handle);
        logic [SEQ_W-1:0] delta;
        bit               found;
        bit               stored;
        int               i;
        if (pred_done || !ok) return;
        if (fin) begin
            pred_done = 1'b1;
            push_result(KIND_FIN, '0, seq, 1'b1);
            return;
        end
        delta = seq - pred_acked;
        if (delta == 32'd1) begin
            pred_acked = seq;
            push_result(KIND_DELIVER, handle, pred_acked, 1'b0);
            // Keep pulling the next number out of the store until a hole shows up.
            do begin
                found = 1'b0;
                for (i = 0; i < WINDOW_DEPTH; i++) begin
                    if (!found && pred_slot_valid[i] &&
                        pred_slot_seq[i] == pred_acked + 32'd1) begin
                        pred_slot_valid[i] = 1'b0;
                        if (pred_held > 0) pred_held--;
                        pred_acked = pred_slot_seq[i];
                        push_result(KIND_DELIVER, pred_slot_ref[i], pred_acked, 1'b0);
                        found = 1'b1;
                    end
                end
            end while (found);
            push_result(KIND_ACK, '0, pred_acked, 1'b1);
            return;
        end
        if (delta < 32'd2 || delta > window_limit()) return;
        if (pred_held >= window_limit()) return;
        for (i = 0; i < WINDOW_DEPTH; i++)
            if (pred_slot_valid[i] && pred_slot_seq[i] == seq) return;
        stored = 1'b0;
        for (i = 0; i < WINDOW_DEPTH; i++) begin
            if (!stored && !pred_slot_valid[i]) begin
                pred_slot_valid[i] = 1'b1;
                pred_slot_seq[i]   = seq;
                pred_slot_ref[i]   = handle;
                pred_held++;
                stored = 1'b1;
            end
        end
        if (stored) push_result(KIND_ACK, '0, pred_acked, 1'b1);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
        mismatch_count++;
    endtask

    // Sender: offers queued headers, with short random gaps unless the run is quiet.
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_headers.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(0, 3);
                s_tvalid <= 1'b0;
            end else begin
                next_hdr = pending_headers.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {next_hdr.payload_ref, next_hdr.seq_num};
                s_tuser  <= {next_hdr.fin_flag, next_hdr.sum_ok};
            end
        end
    end

    // Receiver: random short stalls, and one long hold-off while many headers are waiting,
    // so that the result path backs up into the input.
    always @(negedge aclk) begin
        if (!stall_done && pending_headers.size() > 10 && accepted_items > 60) begin
            stall_left = LONG_STALL_CYCLES;
            stall_done = 1'b1;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (quiet) begin
            m_tready <= 1'b1;
        end else if (ready_gap > 0) begin
            ready_gap--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            ready_gap = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: predicts on accepted headers, checks accepted results, tracks register writes.
    always @(posedge aclk) begin
        in_taken = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                in_taken = 1'b1;
                predict_results(s_tdata[31:0], s_tuser[0], s_tuser[1], s_tdata[47:32]);
                accepted_items++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected, ack", m_tdata[47:16], 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser != want.kind)
                        report_mismatch("kind", 32'(m_tuser), 32'(want.kind));
                    if (m_tdata[15:0] != want.out_ref)
                        report_mismatch("out_ref", 32'(m_tdata[15:0]), 32'(want.out_ref));
                    if (m_tdata[47:16] != want.ack_value)
                        report_mismatch("ack_value", m_tdata[47:16], want.ack_value);
                    if (m_tdata[53:48] != want.free_slots)
                        report_mismatch("free_slots", 32'(m_tdata[53:48]),
                                        32'(want.free_slots));
                    if (m_tlast != want.last)
                        report_mismatch("last", 32'(m_tlast), 32'(want.last));
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_WINDOW) begin
                    pred_window = pwdata[WIN_W-1:0];
                end else if (paddr == ADDR_START_ACK) begin
                    // The start number also reloads the ack number; stored entries stay.
                    pred_acked = pwdata;
                end
            end
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        @(posedge aclk);
    endtask

    task automatic queue_header(input logic [SEQ_W-1:0] seq, input logic ok, input logic fin,
                                input logic [REF_W-1:0] handle);
        header_t h;
        h.seq_num     = seq;
        h.sum_ok      = ok;
        h.fin_flag    = fin;
        h.payload_ref = handle;
        pending_headers.insert(pending_headers.size(), h);
        pushed_count++;
    endtask

    // Waits until every header is taken and every result has come, then lets the block settle.
    task automatic wait_idle();
        while (accepted_items != pushed_count || expected_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Up to one window's worth of sequence numbers in shuffled order, with noise mixed in:
    // failed checksums, late copies and stray numbers.
    task automatic queue_burst(input logic [SEQ_W-1:0] base, input int k);
        logic [SEQ_W-1:0] order [WINDOW_DEPTH];
        logic [SEQ_W-1:0] tmp;
        int               i;
        int               j;
        for (i = 0; i < k; i++) order[i] = base + i + 1;
        for (i = k - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < k; i++) begin
            if ($urandom_range(0, 7) == 0)
                queue_header(order[i], 1'b0, 1'($urandom_range(0, 1)), REF_W'($urandom));
            queue_header(order[i], 1'b1, 1'b0, REF_W'($urandom));
            if ($urandom_range(0, 9) == 0)
                queue_header(order[i], 1'b1, 1'b0, REF_W'($urandom));
            if ($urandom_range(0, 9) == 0)
                queue_header(($urandom_range(0, 1) == 1) ? $urandom : base - $urandom_range(0, 3),
                             1'($urandom_range(0, 1)), 1'b0, REF_W'($urandom));
        end
    endtask

    // Programs both registers while idle, then sends bursts that follow the ack number.
    task automatic run_phase(input logic [WIN_W-1:0] ws, input bit keep_ack,
                             input logic [SEQ_W-1:0] new_ack, input int budget,
                             input int first_k);
        int               start_count;
        int               k;
        int               w;
        logic [SEQ_W-1:0] base;
        start_count = pushed_count;
        apb_write(ADDR_WINDOW, {26'd0, ws});
        apb_write(ADDR_START_ACK, keep_ack ? pred_acked : new_ack);
        base = pred_acked;
        w    = window_limit();
        k    = first_k;
        while (pushed_count - start_count < budget) begin
            if (k == 0) k = (w <= 1) ? 1 : $urandom_range(1, (w < 8) ? w : 8);
            queue_burst(base, k);
            base = base + k;
            k    = 0;
        end
        wait_idle();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Window of 8 from ack 100: in order, stored ahead, bad checksum, duplicate,
        // old, just outside and at the window edge, then drains.
        apb_write(ADDR_WINDOW, 32'd8);
        apb_write(ADDR_START_ACK, 32'd100);
        queue_header(32'd101, 1'b1, 1'b0, 16'h1111);
        queue_header(32'd103, 1'b0, 1'b0, 16'h0bad);
        queue_header(32'd103, 1'b1, 1'b0, 16'h0003);
        queue_header(32'd103, 1'b1, 1'b0, 16'h0033);
        queue_header(32'd105, 1'b1, 1'b0, 16'hffff);
        queue_header(32'd101, 1'b1, 1'b0, 16'h0001);
        queue_header(32'd100, 1'b1, 1'b0, 16'h0000);
        queue_header(32'd110, 1'b1, 1'b0, 16'h0010);
        queue_header(32'd109, 1'b1, 1'b0, 16'h0009);
        queue_header(32'd102, 1'b1, 1'b0, 16'h0002);
        queue_header(32'd104, 1'b1, 1'b0, 16'h0004);
        queue_header(32'hffff_ffff, 1'b0, 1'b1, 16'hffff);
        queue_header(32'd107, 1'b1, 1'b0, 16'h0007);
        queue_header(32'd108, 1'b1, 1'b0, 16'h0008);
        queue_header(32'd106, 1'b1, 1'b0, 16'h0006);
        queue_header(32'hffff_ffff, 1'b1, 1'b0, 16'h0000);
        wait_idle();

        // Leave entries behind, shrink the window below the held count and move the ack
        // number across the wrap, where the store is full; then return and drain them.
        queue_header(32'd111, 1'b1, 1'b0, 16'h0111);
        queue_header(32'd112, 1'b1, 1'b0, 16'h0112);
        queue_header(32'd113, 1'b1, 1'b0, 16'h0113);
        wait_idle();
        apb_write(ADDR_WINDOW, 32'd2);
        apb_write(ADDR_START_ACK, 32'hffff_fffe);
        queue_header(32'hffff_ffff, 1'b1, 1'b0, 16'h8000);
        queue_header(32'd1, 1'b1, 1'b0, 16'h8001);
        queue_header(32'd0, 1'b1, 1'b0, 16'h8002);
        wait_idle();
        apb_write(ADDR_START_ACK, 32'd109);
        apb_write(ADDR_WINDOW, 32'd32);
        queue_header(32'd110, 1'b1, 1'b0, 16'h0110);
        wait_idle();

        // Zero window still delivers in order; an oversized window acts as the full store.
        apb_write(ADDR_WINDOW, 32'd0);
        queue_header(32'd115, 1'b1, 1'b0, 16'h0115);
        queue_header(32'd114, 1'b1, 1'b0, 16'h0114);
        wait_idle();
        apb_write(ADDR_WINDOW, 32'd63);
        queue_header(32'd146, 1'b1, 1'b0, 16'h0146);
        queue_header(32'd147, 1'b1, 1'b0, 16'h0147);
        wait_idle();

        // Random traffic over several window settings and start numbers.
        run_phase(6'd8, 1'b1, '0, 15, 0);
        run_phase(6'd32, 1'b1, '0, 30, 32);
        run_phase(6'd1, 1'b0, $urandom, 12, 0);
        run_phase(6'd63, 1'b0, 32'hffff_fff8, 15, 0);
        run_phase(WIN_W'($urandom_range(1, 32)), 1'b1, '0, 15, 0);
        run_phase(6'd0, 1'b1, '0, 6, 0);
        quiet = 1'b1;
        run_phase(6'd4, 1'b1, '0, 15, 0);

        // A FIN closes the session; nothing after it may produce a result.
        queue_header($urandom, 1'b1, 1'b1, REF_W'($urandom));
        queue_header(pred_acked + 32'd1, 1'b1, 1'b0, REF_W'($urandom));
        queue_header($urandom, 1'b1, 1'b1, REF_W'($urandom));
        wait_idle();

        if (mismatch_count == 0) begin
            $display("sliding_window_reorder_receiver: match");
        end else begin
            $display("sliding_window_reorder_receiver: mismatch");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("sliding_window_reorder_receiver: mismatch");
        $finish;
    end

endmodule

// File: sliding_window_reorder_receiver.f
rtl/swr_pkg.sv
rtl/swr_front.sv
rtl/swr_queue.sv
rtl/swr_back.sv
rtl/sliding_window_reorder_receiver.sv
tb/testbench.sv
